/* hdl/bmra_pkg.sv */
// Package for the bitmap page run allocator: payload structs, status codes,
// state encoding and the word-level search result. No dependencies.
package bmra_pkg;

   localparam int WORD_BITS = 32;
   localparam int COUNT_W   = 11;
   localparam logic [31:0] HEAP_BASE_RESET = 32'h0020_0000;

   // Request kinds carried in req_type.
   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_FREE  = 1'b1;

   typedef enum logic [1:0] {
      ST_ALLOCATED  = 2'd0,
      ST_NO_SPACE   = 2'd1,
      ST_FREED      = 2'd2,
      ST_BELOW_BASE = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_DECODE,
      S_FRANGE,
      S_SCAN,
      S_MODIFY,
      S_RESP
   } state_type;

   typedef struct packed {
      logic                req_type;
      logic [COUNT_W-1:0]  pages;
      logic [31:0]         free_address;
   } req_payload_type;

   typedef struct packed {
      status_type  status;
      logic [31:0] alloc_address;
   } rsp_payload_type;

   // Outcome of searching one bitmap word for the end of a free run.
   typedef struct packed {
      logic               hit;
      logic [4:0]         pos;
      logic [COUNT_W-1:0] run_out;
   } find_type;

endpackage

/* hdl/bmra_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
// Depends on nothing.
module bmra_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/bmra_run_find.sv */
// Searches one 32-page bitmap word for the first page that completes a free
// run of the requested length, carrying the run length in from lower words.
// Depends on bmra_pkg.
module bmra_run_find (
   input  logic [bmra_pkg::WORD_BITS-1:0] used_word,
   input  logic [bmra_pkg::COUNT_W-1:0]   run_in,
   input  logic [bmra_pkg::COUNT_W-1:0]   count,
   output bmra_pkg::find_type             find
);

   logic [4:0]  last_used [bmra_pkg::WORD_BITS];
   logic        seen      [bmra_pkg::WORD_BITS];
   logic [11:0] run_len   [bmra_pkg::WORD_BITS];
   logic [bmra_pkg::WORD_BITS-1:0] hit_vec;

   // For every bit, the length of the free run that ends there.
   always_comb begin
      for (int j = 0; j < bmra_pkg::WORD_BITS; j++) begin
         last_used[j] = 5'd0;
         seen[j]      = 1'b0;
         for (int k = 0; k <= j; k++) begin
            if (used_word[k]) begin
               seen[j]      = 1'b1;
               last_used[j] = 5'(k);
            end
         end
         run_len[j] = seen[j] ? 12'(j - int'(last_used[j]))
                              : 12'(run_in) + 12'(j + 1);
         hit_vec[j] = !used_word[j] && (run_len[j] >= {1'b0, count});
      end
   end

   always_comb begin
      find.pos = 5'd0;
      for (int j = bmra_pkg::WORD_BITS - 1; j >= 0; j--) begin
         if (hit_vec[j]) begin
            find.pos = 5'(j);
         end
      end
      find.hit     = |hit_vec;
      find.run_out = (used_word == '0) ? run_in + bmra_pkg::COUNT_W'(32)
                                       : bmra_pkg::COUNT_W'(5'd31 - last_used[31]);
   end

endmodule

/* hdl/bmra_word_update.sv */
// Sets or clears the bits of one bitmap word that fall inside an inclusive
// page range. Depends on bmra_pkg.
module bmra_word_update #(
   parameter int PAGE_W = 11
) (
   input  logic [bmra_pkg::WORD_BITS-1:0] old_word,
   input  logic [PAGE_W-6:0]              word_idx,
   input  logic [PAGE_W-1:0]              lo_page,
   input  logic [PAGE_W-1:0]              hi_page,
   input  logic                           set_bits,
   output logic [bmra_pkg::WORD_BITS-1:0] new_word
);

   logic [4:0]                     lo_bit;
   logic [4:0]                     hi_bit;
   logic [bmra_pkg::WORD_BITS-1:0] mask;

   always_comb begin
      lo_bit   = (word_idx == lo_page[PAGE_W-1:5]) ? lo_page[4:0] : 5'd0;
      hi_bit   = (word_idx == hi_page[PAGE_W-1:5]) ? hi_page[4:0] : 5'd31;
      mask     = ({bmra_pkg::WORD_BITS{1'b1}} << lo_bit) &
                 ({bmra_pkg::WORD_BITS{1'b1}} >> (5'd31 - hi_bit));
      new_word = set_bits ? (old_word | mask) : (old_word & ~mask);
   end

endmodule

/* hdl/page_bitmap_run_allocator.sv */
// Top level of the bitmap first-fit contiguous page allocator.
// Depends on bmra_pkg, bmra_ram, bmra_run_find and bmra_word_update.
//
//   Channel   Ports                        Moves
//   request   req_valid/req_ready/req_data one allocate or free per transfer
//   response  rsp_valid/rsp_ready/rsp_data one status and address per request
//   config    csr_wr_en/csr_wr_data        heap_base, written at once
//
// An allocate scans the bitmap words from the lowest until the first fitting
// run ends or the last word is searched, then reads, modifies and writes back
// each word the run touches; the bitmap memory is walked one word per cycle.
// A free decodes the address and the page range, then updates each word in it.
// After reset a clearing pass writes every bitmap word to zero, one word per
// cycle, and no request is taken until it ends.
// A finished response waits in the output register, so the next request is
// taken while the previous response is still unclaimed.
module page_bitmap_run_allocator #(
   parameter int NUM_PAGES  = 1024,
   parameter int PAGE_SHIFT = 12
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  bmra_pkg::req_payload_type req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output bmra_pkg::rsp_payload_type rsp_data,
   input  logic                      csr_wr_en,
   input  logic [31:0]               csr_wr_data
);

   localparam int WORDS     = (NUM_PAGES + 31) / 32;
   localparam int WW        = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int WCW       = $clog2(WORDS + 1);
   localparam int PIW       = $clog2(NUM_PAGES + 1);
   localparam int FW        = 32 - PAGE_SHIFT;
   localparam int OFW       = PIW + PAGE_SHIFT;
   localparam int TAIL      = NUM_PAGES % 32;
   localparam int LAST_WORD = WORDS - 1;
   // Bits of the last word that lie past the final page read as used.
   localparam logic [31:0] TAIL_MASK =
      (TAIL == 0) ? 32'd0 : ~((32'd1 << TAIL) - 32'd1);

   // Control registers.
   bmra_pkg::state_type state_ff, state_in;
   logic [31:0]         heap_base_ff, heap_base_in;
   logic [WCW-1:0]      rd_word_ff, rd_word_in;
   logic                pend_ff, pend_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // Payload registers.
   bmra_pkg::req_payload_type     req_ff, req_in;
   logic [FW-1:0]                 first_ff, first_in;
   logic [PIW-1:0]                lo_ff, lo_in;
   logic [PIW-1:0]                hi_ff, hi_in;
   logic                          set_ff, set_in;
   logic [WW-1:0]                 proc_word_ff, proc_word_in;
   logic [bmra_pkg::COUNT_W-1:0]  run_ff, run_in;
   bmra_pkg::status_type          status_ff, status_in;
   bmra_pkg::rsp_payload_type     rsp_data_ff, rsp_data_in;

   // Memory port.
   logic          ram_wr_en;
   logic [WW-1:0] ram_wr_addr;
   logic [31:0]   ram_wr_data;
   logic          ram_rd_en;
   logic [WW-1:0] ram_rd_addr;
   logic [31:0]   ram_rd_data;

   // Datapath.
   logic               below_base;
   logic [31:0]        addr_diff;
   logic [32:0]        end_excl;
   logic [32:0]        end_clamp;
   logic               none_to_free;
   logic [PIW-1:0]     hit_page;
   logic [PIW-1:0]     start_page;
   logic [WCW-1:0]     hi_word;
   logic [31:0]        scan_word;
   logic [31:0]        upd_word;
   logic [OFW-1:0]     offset;
   bmra_pkg::find_type find;

   bmra_ram #(
      .WIDTH (32),
      .DEPTH (WORDS)
   ) u_bitmap (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   bmra_run_find u_find (
      .used_word (scan_word),
      .run_in    (run_ff),
      .count     (req_ff.pages),
      .find      (find)
   );

   bmra_word_update #(
      .PAGE_W (PIW)
   ) u_update (
      .old_word (ram_rd_data),
      .word_idx ((PIW-5)'(proc_word_ff)),
      .lo_page  (lo_ff),
      .hi_page  (hi_ff),
      .set_bits (set_ff),
      .new_word (upd_word)
   );

   // Arithmetic shared by the states below.
   always_comb begin
      below_base   = req_ff.free_address < heap_base_ff;
      addr_diff    = req_ff.free_address - heap_base_ff;
      end_excl     = 33'(first_ff) + 33'(req_ff.pages);
      end_clamp    = (end_excl > 33'(NUM_PAGES)) ? 33'(NUM_PAGES) : end_excl;
      none_to_free = (req_ff.pages == '0) || (33'(first_ff) >= 33'(NUM_PAGES));
      hit_page     = PIW'({proc_word_ff, find.pos});
      start_page   = hit_page + PIW'(1) - PIW'(req_ff.pages);
      hi_word      = WCW'(hi_ff >> 5);
      scan_word    = ram_rd_data |
                     ((proc_word_ff == WW'(LAST_WORD)) ? TAIL_MASK : 32'd0);
      offset       = OFW'(lo_ff) << PAGE_SHIFT;
      heap_base_in = csr_wr_en ? csr_wr_data : heap_base_ff;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bmra_pkg::S_CLEAR: begin
            if (rd_word_ff == WCW'(LAST_WORD)) begin
               state_in = bmra_pkg::S_IDLE;
            end
         end
         bmra_pkg::S_IDLE: begin
            if (req_valid) begin
               if (req_data.req_type == bmra_pkg::REQ_FREE) begin
                  state_in = bmra_pkg::S_DECODE;
               end else if (req_data.pages == '0) begin
                  state_in = bmra_pkg::S_RESP;
               end else begin
                  state_in = bmra_pkg::S_SCAN;
               end
            end
         end
         bmra_pkg::S_DECODE: begin
            state_in = below_base ? bmra_pkg::S_RESP : bmra_pkg::S_FRANGE;
         end
         bmra_pkg::S_FRANGE: begin
            state_in = none_to_free ? bmra_pkg::S_RESP : bmra_pkg::S_MODIFY;
         end
         bmra_pkg::S_SCAN: begin
            priority if (pend_ff && find.hit) begin
               state_in = bmra_pkg::S_MODIFY;
            end else if (pend_ff && (proc_word_ff == WW'(LAST_WORD))) begin
               state_in = bmra_pkg::S_RESP;
            end else begin
               state_in = bmra_pkg::S_SCAN;
            end
         end
         bmra_pkg::S_MODIFY: begin
            if (pend_ff && (WCW'(proc_word_ff) == hi_word)) begin
               state_in = bmra_pkg::S_RESP;
            end
         end
         bmra_pkg::S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = bmra_pkg::S_IDLE;
            end
         end
         default: state_in = bmra_pkg::S_CLEAR;
      endcase
   end

   // Register updates and memory accesses for each state.
   always_comb begin
      req_in       = req_ff;
      first_in     = first_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      set_in       = set_ff;
      rd_word_in   = rd_word_ff;
      proc_word_in = proc_word_ff;
      pend_in      = pend_ff;
      run_in       = run_ff;
      status_in    = status_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = proc_word_ff;
      ram_wr_data  = upd_word;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = rd_word_ff[WW-1:0];

      unique case (state_ff)
         bmra_pkg::S_CLEAR: begin
            // Every page starts free: zero one word per cycle.
            ram_wr_en   = 1'b1;
            ram_wr_addr = rd_word_ff[WW-1:0];
            ram_wr_data = 32'd0;
            rd_word_in  = rd_word_ff + WCW'(1);
         end
         bmra_pkg::S_IDLE: begin
            if (req_valid) begin
               req_in     = req_data;
               rd_word_in = '0;
               pend_in    = 1'b0;
               run_in     = '0;
               status_in  = bmra_pkg::ST_NO_SPACE;
            end
         end
         bmra_pkg::S_DECODE: begin
            first_in  = FW'(addr_diff >> PAGE_SHIFT);
            status_in = below_base ? bmra_pkg::ST_BELOW_BASE : bmra_pkg::ST_FREED;
         end
         bmra_pkg::S_FRANGE: begin
            // Pages past the end are dropped by clamping the top of the range.
            lo_in      = PIW'(first_ff);
            hi_in      = PIW'(end_clamp - 33'd1);
            set_in     = 1'b0;
            rd_word_in = WCW'(PIW'(first_ff) >> 5);
            pend_in    = 1'b0;
         end
         bmra_pkg::S_SCAN: begin
            // Reads run one word ahead of the search.
            if (rd_word_ff < WCW'(WORDS)) begin
               ram_rd_en    = 1'b1;
               proc_word_in = rd_word_ff[WW-1:0];
               rd_word_in   = rd_word_ff + WCW'(1);
               pend_in      = 1'b1;
            end else begin
               pend_in = 1'b0;
            end
            if (pend_ff) begin
               if (find.hit) begin
                  lo_in      = start_page;
                  hi_in      = hit_page;
                  set_in     = 1'b1;
                  status_in  = bmra_pkg::ST_ALLOCATED;
                  rd_word_in = WCW'(start_page >> 5);
                  pend_in    = 1'b0;
               end else begin
                  run_in = find.run_out;
               end
            end
         end
         bmra_pkg::S_MODIFY: begin
            // Read-modify-write one word per cycle; the write always trails
            // the read by one word, so the two never meet on one entry.
            if (rd_word_ff <= hi_word) begin
               ram_rd_en    = 1'b1;
               proc_word_in = rd_word_ff[WW-1:0];
               rd_word_in   = rd_word_ff + WCW'(1);
               pend_in      = 1'b1;
            end else begin
               pend_in = 1'b0;
            end
            if (pend_ff) begin
               ram_wr_en = 1'b1;
            end
         end
         bmra_pkg::S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in       = 1'b1;
               rsp_data_in.status = status_ff;
               rsp_data_in.alloc_address =
                  (status_ff == bmra_pkg::ST_ALLOCATED) ? heap_base_ff + 32'(offset)
                                                        : 32'd0;
            end
         end
         default: begin
            rd_word_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bmra_pkg::S_CLEAR;
         heap_base_ff <= bmra_pkg::HEAP_BASE_RESET;
         rd_word_ff   <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         heap_base_ff <= heap_base_in;
         rd_word_ff   <= rd_word_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      first_ff     <= first_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      set_ff       <= set_in;
      proc_word_ff <= proc_word_in;
      run_ff       <= run_in;
      status_ff    <= status_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign req_ready = (state_ff == bmra_pkg::S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // The read-modify-write never reads the entry that it writes in that cycle.
   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      (ram_wr_en && ram_rd_en) |-> (ram_wr_addr != ram_rd_addr))
      else $error("bitmap read and write hit the same word");

   // While searching, the carried run is always shorter than the request.
   a_run_below_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bmra_pkg::S_SCAN) |-> (run_ff < req_ff.pages))
      else $error("carried run reached the count without a hit");

   // A request transfer closes the request side until that request is done.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while another is in progress");

endmodule

/* bench/tb_page_bitmap_run_allocator.sv */
// Self-checking testbench for page_bitmap_run_allocator: first-fit allocation and freeing.
// It predicts every response from its own copy of the page bitmap and heap base.
// Depends on bmra_pkg and the allocator RTL, and on nothing else.
module tb_page_bitmap_run_allocator;

   localparam int PAGE_TOTAL  = 1024;
   localparam int PAGE_BITS   = 12;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int PHASE_ITEMS = 116;
   localparam int BACKLOG_MAX = 4;

   // A run that the prediction says was granted, kept so that later frees can
   // hand back real allocations rather than random ranges.
   typedef struct {
      logic [31:0] base_addr;
      int          pages;
   } held_run_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   bmra_pkg::req_payload_type req_data = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   bmra_pkg::rsp_payload_type rsp_data;
   logic                      csr_wr_en = 1'b0;
   logic [31:0]               csr_wr_data = '0;

   // Predicted state of the block: one used flag per page and the heap base.
   bit                        page_taken [PAGE_TOTAL];
   logic [31:0]               base_model = bmra_pkg::HEAP_BASE_RESET;

   bmra_pkg::req_payload_type queued_requests [$];
   bmra_pkg::rsp_payload_type awaited_outcomes [$];
   held_run_type              live_runs [$];

   int                        send_idle_pct = 0;
   int                        rsp_stall_pct = 0;
   int                        mismatch_count = 0;
   int                        cycle_count = 0;
   int                        config_writes = 0;
   int                        accepted_total = 0;
   int                        tally [4] = '{0, 0, 0, 0};
   logic [31:0]               phase_bases [8];

   page_bitmap_run_allocator #(
      .NUM_PAGES (PAGE_TOTAL),
      .PAGE_SHIFT(PAGE_BITS)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Applies one request to the predicted bitmap and returns the response it
   // must produce. An allocate looks for the lowest run of free pages of the
   // requested length; a free clears pages from the addressed one upwards and
   // quietly drops any page beyond the end of the map.
   function automatic bmra_pkg::rsp_payload_type apply_to_page_map(
      bmra_pkg::req_payload_type r);
      bmra_pkg::rsp_payload_type outcome;
      int                        run_len;
      int                        run_start;
      int                        lead_page;
      int                        p;
      bit                        hit;
      outcome.status        = bmra_pkg::ST_NO_SPACE;
      outcome.alloc_address = '0;
      if (r.req_type == bmra_pkg::REQ_ALLOC) begin
         run_len   = 0;
         run_start = 0;
         hit       = 1'b0;
         if (r.pages != 0) begin
            for (p = 0; p < PAGE_TOTAL && !hit; p++) begin
               if (!page_taken[p]) begin
                  if (run_len == 0) begin
                     run_start = p;
                  end
                  run_len++;
                  if (run_len == int'(r.pages)) begin
                     hit = 1'b1;
                  end
               end else begin
                  run_len = 0;
               end
            end
         end
         if (hit) begin
            for (p = run_start; p < run_start + int'(r.pages); p++) begin
               page_taken[p] = 1'b1;
            end
            outcome.status = bmra_pkg::ST_ALLOCATED;
            // The sum is kept to 32 bits, so a high base wraps past zero.
            outcome.alloc_address = base_model + (32'(run_start) << PAGE_BITS);
         end
      end else if (r.free_address < base_model) begin
         outcome.status = bmra_pkg::ST_BELOW_BASE;
      end else begin
         lead_page = int'((r.free_address - base_model) >> PAGE_BITS);
         for (p = lead_page; p < lead_page + int'(r.pages); p++) begin
            if (p < PAGE_TOTAL) begin
               page_taken[p] = 1'b0;
            end
         end
         outcome.status = bmra_pkg::ST_FREED;
      end
      return outcome;
   endfunction

   // Request driver. The prediction is made at the edge where the transfer
   // happens, so the expected responses line up with the order of acceptance.
   // Valid is only assigned once per edge: it either stays up with the same
   // payload, moves on to the next queued request, or drops for a gap.
   always @(posedge clock) begin
      bmra_pkg::rsp_payload_type outcome;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            outcome = apply_to_page_map(req_data);
            awaited_outcomes.push_back(outcome);
            tally[outcome.status]++;
            accepted_total++;
            if (outcome.status == bmra_pkg::ST_ALLOCATED) begin
               live_runs.push_back('{outcome.alloc_address, int'(req_data.pages)});
            end
         end
         if (!req_valid || req_ready) begin
            if (queued_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_data  <= queued_requests.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor. Each response transfer is compared field by field with
   // the oldest prediction; ready is redrawn every cycle to give back-pressure.
   always @(posedge clock) begin
      bmra_pkg::rsp_payload_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (awaited_outcomes.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("cycle %0d: response with nothing outstanding, %s %0d address %h",
                           cycle_count, "status", rsp_data.status,
                           rsp_data.alloc_address);
               end
            end else begin
               want = awaited_outcomes.pop_front();
               if (rsp_data.status !== want.status ||
                   rsp_data.alloc_address !== want.alloc_address) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("cycle %0d: expected status %0d address %h,",
                              cycle_count, want.status, want.alloc_address,
                              " got status %0d address %h",
                              rsp_data.status, rsp_data.alloc_address);
                  end
               end
            end
         end
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Watchdog: a hang anywhere ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   function automatic void queue_req(logic kind, int count, logic [31:0] addr);
      bmra_pkg::req_payload_type r;
      r.req_type     = kind;
      r.pages        = bmra_pkg::COUNT_W'(count);
      r.free_address = addr;
      queued_requests.push_back(r);
   endfunction

   // Waits until every queued request has been transferred and every response
   // has come back. Called on the falling edge, away from the driving edge.
   task automatic drain_bench();
      @(negedge clock);
      while (queued_requests.size() != 0 || req_valid ||
             awaited_outcomes.size() != 0) begin
         @(negedge clock);
      end
   endtask

   // The register only changes while the block is idle, so the predicted base
   // can follow it straight away. Runs granted under the old base are dropped.
   task automatic write_heap_base(logic [31:0] value);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      @(negedge clock);
      base_model = value;
      live_runs.delete();
      config_writes++;
   endtask

   // Most traffic is well formed: allocations of mostly modest size, and frees
   // that return runs granted earlier, sometimes only in part. The rest is
   // noise with random kind, count and address.
   task automatic queue_random_request();
      bmra_pkg::req_payload_type r;
      held_run_type              run;
      int                        pick;
      int                        slot;
      r.req_type     = bmra_pkg::REQ_ALLOC;
      r.free_address = $urandom();
      pick = $urandom_range(99);
      if (pick < 12) begin
         r.req_type = logic'($urandom_range(1));
         r.pages    = bmra_pkg::COUNT_W'($urandom_range(1024));
      end else if (pick < 55 && live_runs.size() != 0) begin
         slot = $urandom_range(live_runs.size() - 1);
         run  = live_runs[slot];
         live_runs.delete(slot);
         r.req_type     = bmra_pkg::REQ_FREE;
         r.free_address = run.base_addr + $urandom_range(4095);
         if ($urandom_range(99) < 15) begin
            r.pages = bmra_pkg::COUNT_W'($urandom_range(run.pages));
         end else begin
            r.pages = bmra_pkg::COUNT_W'(run.pages);
         end
      end else begin
         pick = $urandom_range(99);
         if (pick < 60) begin
            r.pages = bmra_pkg::COUNT_W'($urandom_range(16, 1));
         end else if (pick < 85) begin
            r.pages = bmra_pkg::COUNT_W'($urandom_range(128, 17));
         end else if (pick < 97) begin
            r.pages = bmra_pkg::COUNT_W'($urandom_range(1024, 129));
         end else begin
            r.pages = '0;
         end
      end
      queued_requests.push_back(r);
   endtask

   initial begin
      int phase;
      int k;
      phase_bases = '{bmra_pkg::HEAP_BASE_RESET, 32'h0000_0000, 32'hFFFF_FFFF,
                      32'hFFE0_0000, $urandom(), 32'h0000_1000, $urandom(),
                      32'h8000_0000};
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part at the reset base: zero and oversized counts, a full
      // heap, frees below the base, past the end, of free pages and of zero
      // pages, and a first fit that has to land in a hole.
      queue_req(bmra_pkg::REQ_ALLOC, 0, 32'h0);
      queue_req(bmra_pkg::REQ_ALLOC, 1, 32'hFFFF_FFFF);
      queue_req(bmra_pkg::REQ_ALLOC, 1024, 32'h0);
      queue_req(bmra_pkg::REQ_ALLOC, 2, 32'h0);
      queue_req(bmra_pkg::REQ_FREE, 1, bmra_pkg::HEAP_BASE_RESET + 32'h1123);
      queue_req(bmra_pkg::REQ_ALLOC, 1, 32'h0);
      queue_req(bmra_pkg::REQ_ALLOC, 1022, 32'h0);
      queue_req(bmra_pkg::REQ_ALLOC, 1021, 32'h0);
      queue_req(bmra_pkg::REQ_ALLOC, 1, 32'h0);
      queue_req(bmra_pkg::REQ_FREE, 1024, bmra_pkg::HEAP_BASE_RESET);
      queue_req(bmra_pkg::REQ_FREE, 4, bmra_pkg::HEAP_BASE_RESET - 1);
      queue_req(bmra_pkg::REQ_FREE, 0, 32'h0);
      queue_req(bmra_pkg::REQ_FREE, 0, bmra_pkg::HEAP_BASE_RESET);
      queue_req(bmra_pkg::REQ_FREE, 1024,
                bmra_pkg::HEAP_BASE_RESET + (32'd1023 << PAGE_BITS));
      queue_req(bmra_pkg::REQ_FREE, 1024, 32'hFFFF_FFFF);
      queue_req(bmra_pkg::REQ_FREE, 8, bmra_pkg::HEAP_BASE_RESET);
      queue_req(bmra_pkg::REQ_ALLOC, 1024, 32'h0);
      queue_req(bmra_pkg::REQ_FREE, 5,
                bmra_pkg::HEAP_BASE_RESET + (32'd10 << PAGE_BITS));
      queue_req(bmra_pkg::REQ_ALLOC, 6, 32'h0);
      queue_req(bmra_pkg::REQ_ALLOC, 5, 32'h0);
      queue_req(bmra_pkg::REQ_FREE, 1024, bmra_pkg::HEAP_BASE_RESET);
      drain_bench();

      // A base one page short of the top: the second page wraps to zero and
      // must still be reported as allocated.
      write_heap_base(32'hFFFF_F000);
      queue_req(bmra_pkg::REQ_ALLOC, 1, 32'h0);
      queue_req(bmra_pkg::REQ_ALLOC, 1, 32'h0);
      queue_req(bmra_pkg::REQ_FREE, 1, 32'h0);
      queue_req(bmra_pkg::REQ_FREE, 1024, 32'hFFFF_F000);
      drain_bench();

      // Random phases, each with its own base and one of four idling patterns. Halfway
      // through every phase the sender holds off until all responses are in.
      for (phase = 0; phase < 8; phase++) begin
         drain_bench();
         write_heap_base(phase_bases[phase]);
         case (phase % 4)
            0: begin
               send_idle_pct = 0;
               rsp_stall_pct = 0;
            end
            1: begin
               send_idle_pct = 68;
               rsp_stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               rsp_stall_pct = 68;
            end
            default: begin
               send_idle_pct = 27;
               rsp_stall_pct = 27;
            end
         endcase
         queue_req(bmra_pkg::REQ_FREE, 1024, base_model);
         for (k = 0; k < PHASE_ITEMS; k++) begin
            if (k == PHASE_ITEMS / 2) begin
               drain_bench();
            end
            while (queued_requests.size() >= BACKLOG_MAX) begin
               @(negedge clock);
            end
            queue_random_request();
         end
      end

      drain_bench();
      repeat (100) @(negedge clock);
      if (awaited_outcomes.size() != 0) begin
         mismatch_count++;
      end
      $display("Run covered %0d requests under %0d heap base settings and four %s",
               accepted_total, config_writes + 1, "idling patterns.");
      $display("Outcomes: %0d granted, %0d refused, %0d released, %0d %s",
               tally[bmra_pkg::ST_ALLOCATED], tally[bmra_pkg::ST_NO_SPACE],
               tally[bmra_pkg::ST_FREED], tally[bmra_pkg::ST_BELOW_BASE],
               "ignored below the base.");
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

/* sim.f */
hdl/bmra_pkg.sv
hdl/bmra_ram.sv
hdl/bmra_run_find.sv
hdl/bmra_word_update.sv
hdl/page_bitmap_run_allocator.sv
bench/tb_page_bitmap_run_allocator.sv
